/* sv/srtc_pkg.sv */
// ----------------------------------------------------------------------------
// srtc_pkg
// Types, codes and constants shared by the serial request timeout controller.
// ----------------------------------------------------------------------------
`default_nettype none

package srtc_pkg;

    // Tick counter width and the compare width that also covers 8-bit limits
    localparam int TIMER_BITS = 8;
    localparam int CMP_W      = (TIMER_BITS > 8) ? TIMER_BITS : 8;
    localparam int TX_GRACE   = 1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TX_TIMEOUT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_RX_THRESH  = 8'd3;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Transfer phase codes
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SEND   = 3'd1;
    localparam logic [2:0] PH_RECV   = 3'd2;
    localparam logic [2:0] PH_TX_TO  = 3'd4;
    localparam logic [2:0] PH_RX_TO  = 3'd5;
    localparam logic [2:0] PH_FINISH = 3'd6;

    typedef struct packed {
        logic op;
        logic tx_active;
        logic tx_data_pending;
        logic tx_shift_empty;
        logic rx_end;
        logic response_valid;
    } srtc_item_t;

    typedef struct packed {
        logic       start_tx;
        logic       stop_tx;
        logic       rx_end_clear;
        logic       busy_res;
        logic       frame_accepted;
        logic       ack;
        logic       tx_timeout_flag;
        logic       rx_timeout_flag;
        logic       error;
        logic       no_receiver;
        logic [7:0] fail_count;
    } srtc_result_t;

    typedef struct packed {
        logic [7:0] tx_timeout;
        logic [7:0] rx_timeout;
        logic [7:0] fail_limit;
        logic [7:0] no_receiver_threshold;
    } srtc_cfg_t;

endpackage

`default_nettype wire

/* sv/srtc_ifs.sv */
// ----------------------------------------------------------------------------
// srtc_ifs
// Valid/ready channel interfaces: request items, result items, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface srtc_req_if;
    logic valid;
    logic ready;
    logic op;
    logic tx_active;
    logic tx_data_pending;
    logic tx_shift_empty;
    logic rx_end;
    logic response_valid;

    modport source (output valid, op, tx_active, tx_data_pending, tx_shift_empty,
                    rx_end, response_valid, input ready);
    modport sink   (input valid, op, tx_active, tx_data_pending, tx_shift_empty,
                    rx_end, response_valid, output ready);
endinterface

interface srtc_rsp_if;
    logic       valid;
    logic       ready;
    logic       start_tx;
    logic       stop_tx;
    logic       rx_end_clear;
    logic       busy_res;
    logic       frame_accepted;
    logic       ack;
    logic       tx_timeout_flag;
    logic       rx_timeout_flag;
    logic       error;
    logic       no_receiver;
    logic [7:0] fail_count;

    modport source (output valid, start_tx, stop_tx, rx_end_clear, busy_res,
                    frame_accepted, ack, tx_timeout_flag, rx_timeout_flag, error,
                    no_receiver, fail_count, input ready);
    modport sink   (input valid, start_tx, stop_tx, rx_end_clear, busy_res,
                    frame_accepted, ack, tx_timeout_flag, rx_timeout_flag, error,
                    no_receiver, fail_count, output ready);
endinterface

interface srtc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/srtc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// srtc_cfg_regs
// Timeout, failure limit and threshold registers behind the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    srtc_cfg_if.sink               cfg,
    output srtc_pkg::srtc_cfg_t    cfg_out
);
    import srtc_pkg::*;

    srtc_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Ignore writes to indexes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_timeout            <= 8'd10;
            cfg_reg.rx_timeout            <= 8'd20;
            cfg_reg.fail_limit            <= 8'd10;
            cfg_reg.no_receiver_threshold <= 8'd3;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TX_TIMEOUT:   cfg_reg.tx_timeout            <= cfg.data;
                CFG_RX_TIMEOUT:   cfg_reg.rx_timeout            <= cfg.data;
                CFG_FAIL_LIMIT:   cfg_reg.fail_limit            <= cfg.data;
                CFG_NO_RX_THRESH: cfg_reg.no_receiver_threshold <= cfg.data;
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/srtc_ctrl.sv */
// ----------------------------------------------------------------------------
// srtc_ctrl
// Exchange state and single-pass next-state logic for one tick or poll.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire srtc_pkg::srtc_item_t item,
    input  wire srtc_pkg::srtc_cfg_t  cfg,
    output srtc_pkg::srtc_result_t    result
);
    import srtc_pkg::*;

    localparam logic [TIMER_BITS-1:0] TICK_MAX = '1;

    logic                  req_phase_reg,   req_phase_next;
    logic [2:0]            phase_reg,       phase_next;
    logic                  in_xfer_reg,     in_xfer_next;
    logic [TIMER_BITS-1:0] tick_reg,        tick_next;
    logic                  ok_reg,          ok_next;
    logic                  tx_to_reg,       tx_to_next;
    logic                  rx_to_reg,       rx_to_next;
    logic                  ack_reg,         ack_next;
    logic                  err_reg,         err_next;
    logic                  absent_reg,      absent_next;
    logic [7:0]            fail_reg,        fail_next;

    logic cmd_start, cmd_stop, cmd_rx_clear, accepted;
    logic [2:0] ph;
    logic       done;
    logic       failed;

    always_comb
    begin
        req_phase_next = req_phase_reg;
        phase_next     = phase_reg;
        in_xfer_next   = in_xfer_reg;
        tick_next      = tick_reg;
        ok_next        = ok_reg;
        tx_to_next     = tx_to_reg;
        rx_to_next     = rx_to_reg;
        ack_next       = ack_reg;
        err_next       = err_reg;
        absent_next    = absent_reg;
        fail_next      = fail_reg;
        cmd_start      = 1'b0;
        cmd_stop       = 1'b0;
        cmd_rx_clear   = 1'b0;
        accepted       = 1'b0;
        ph             = PH_START;
        done           = 1'b0;
        failed         = 1'b0;

        if (item.op == OP_TICK)
        begin
            if (tick_reg != TICK_MAX)
                tick_next = tick_reg + 1'b1;
        end
        else if (!req_phase_reg || in_xfer_reg)
        begin
            // Transfer step; a fresh request enters at the start phase
            req_phase_next = 1'b1;
            in_xfer_next   = 1'b1;
            ph             = req_phase_reg ? phase_reg : PH_START;

            if (ph == PH_START)
            begin
                cmd_start = 1'b1;
                tick_next = '0;
                ph        = PH_SEND;
            end
            if (ph == PH_SEND)
            begin
                if (item.tx_active)
                begin
                    if ((CMP_W'(tick_next) > CMP_W'(TX_GRACE) && !item.tx_data_pending) ||
                        CMP_W'(tick_next) > CMP_W'(cfg.tx_timeout))
                        ph = PH_TX_TO;
                    phase_next = ph;
                    done       = 1'b1;
                end
                else
                begin
                    tx_to_next = 1'b0;
                    if (!item.tx_shift_empty)
                    begin
                        phase_next = PH_SEND;
                        done       = 1'b1;
                    end
                    else
                    begin
                        cmd_stop  = 1'b1;
                        tick_next = '0;
                        ph        = PH_RECV;
                    end
                end
            end
            if (!done && ph == PH_RECV)
            begin
                if (!item.rx_end)
                begin
                    phase_next = (CMP_W'(tick_next) < CMP_W'(cfg.rx_timeout)) ?
                                 PH_RECV : PH_RX_TO;
                end
                else
                begin
                    cmd_rx_clear = 1'b1;
                    ok_next      = 1'b1;
                    tx_to_next   = 1'b0;
                    rx_to_next   = 1'b0;
                    phase_next   = PH_FINISH;
                end
                done = 1'b1;
            end
            if (!done && ph == PH_TX_TO)
            begin
                tx_to_next = 1'b1;
                ok_next    = 1'b0;
                cmd_stop   = 1'b1;
                phase_next = PH_FINISH;
                done       = 1'b1;
            end
            if (!done)
            begin
                // Finish, receive timeout, and the unused codes that behave as finish
                if (ph == PH_RX_TO)
                begin
                    rx_to_next = 1'b1;
                    ok_next    = 1'b0;
                end
                in_xfer_next = 1'b0;
                phase_next   = PH_START;
            end
        end
        else
        begin
            // Judge the finished exchange
            req_phase_next = 1'b0;
            if (ok_reg && item.response_valid)
            begin
                fail_next   = '0;
                absent_next = 1'b0;
                ack_next    = 1'b1;
                accepted    = 1'b1;
            end
            else
            begin
                ack_next = 1'b0;
                failed   = tx_to_reg | rx_to_reg;
                if (failed)
                begin
                    if (fail_reg < cfg.fail_limit)
                        fail_next = fail_reg + 1'b1;
                end
                else
                begin
                    fail_next = '0;
                end
                absent_next = (fail_next > cfg.no_receiver_threshold);
                err_next    = failed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_phase_reg <= 1'b0;
            phase_reg     <= PH_START;
            in_xfer_reg   <= 1'b0;
            tick_reg      <= '0;
            ok_reg        <= 1'b0;
            tx_to_reg     <= 1'b0;
            rx_to_reg     <= 1'b0;
            ack_reg       <= 1'b0;
            err_reg       <= 1'b0;
            absent_reg    <= 1'b0;
            fail_reg      <= '0;
        end
        else if (fire)
        begin
            req_phase_reg <= req_phase_next;
            phase_reg     <= phase_next;
            in_xfer_reg   <= in_xfer_next;
            tick_reg      <= tick_next;
            ok_reg        <= ok_next;
            tx_to_reg     <= tx_to_next;
            rx_to_reg     <= rx_to_next;
            ack_reg       <= ack_next;
            err_reg       <= err_next;
            absent_reg    <= absent_next;
            fail_reg      <= fail_next;
        end
    end

    assign result.start_tx        = cmd_start;
    assign result.stop_tx         = cmd_stop;
    assign result.rx_end_clear    = cmd_rx_clear;
    assign result.busy_res        = in_xfer_next;
    assign result.frame_accepted  = accepted;
    assign result.ack             = ack_next;
    assign result.tx_timeout_flag = tx_to_next;
    assign result.rx_timeout_flag = rx_to_next;
    assign result.error           = err_next;
    assign result.no_receiver     = absent_next;
    assign result.fail_count      = fail_next;

endmodule

`default_nettype wire

/* sv/serial_request_timeout_controller_core.sv */
// ----------------------------------------------------------------------------
// serial_request_timeout_controller_core
// UART request/response exchange controller with transmit and receive
// timeouts, consecutive failure counting and a no-receiver flag.
// ----------------------------------------------------------------------------
//
//  channel  role  transaction                      payload
//  -------  ----  -------------------------------  -----------------------------
//  req      sink  one tick or poll with UART status op, tx_*, rx_end, resp valid
//  rsp      src   one result per req transaction    strobes, flags, fail_count
//  cfg      sink  one register write (always ready) index, data
//
//  Throughput: one req transaction per cycle, sustained while rsp is ready.
//  Path: a req transaction moves from the input register through the
//  single-pass logic into the result register; the state updates as the
//  transaction leaves the input register.
//  Reset clears the exchange state and loads the register defaults.
//  A stalled rsp holds its result; req keeps flowing into the input register
//  until both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_request_timeout_controller_core (
    input  wire logic clk,
    input  wire logic rst_n,
    srtc_req_if.sink  req,
    srtc_rsp_if.source rsp,
    srtc_cfg_if.sink  cfg
);
    import srtc_pkg::*;

    srtc_item_t   item_reg;
    logic         item_valid_reg;
    srtc_result_t rsp_reg;
    logic         rsp_valid_reg;

    srtc_cfg_t    cfg_cur;
    srtc_result_t result;
    logic         advance;
    logic         fire;

    // Advance the pipe when the result register is free or being drained
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = item_valid_reg && advance;
    assign req.ready = !item_valid_reg || advance;

    srtc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    srtc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg_cur),
        .result (result)
    );

    // Input register: take a transaction whenever it is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req.ready)
            item_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.op              <= req.op;
            item_reg.tx_active       <= req.tx_active;
            item_reg.tx_data_pending <= req.tx_data_pending;
            item_reg.tx_shift_empty  <= req.tx_shift_empty;
            item_reg.rx_end          <= req.rx_end;
            item_reg.response_valid  <= req.response_valid;
        end
    end

    // Result register: hold while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= result;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.start_tx        = rsp_reg.start_tx;
    assign rsp.stop_tx         = rsp_reg.stop_tx;
    assign rsp.rx_end_clear    = rsp_reg.rx_end_clear;
    assign rsp.busy_res        = rsp_reg.busy_res;
    assign rsp.frame_accepted  = rsp_reg.frame_accepted;
    assign rsp.ack             = rsp_reg.ack;
    assign rsp.tx_timeout_flag = rsp_reg.tx_timeout_flag;
    assign rsp.rx_timeout_flag = rsp_reg.rx_timeout_flag;
    assign rsp.error           = rsp_reg.error;
    assign rsp.no_receiver     = rsp_reg.no_receiver;
    assign rsp.fail_count      = rsp_reg.fail_count;

    // A held item must not be dropped while the result side stalls
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("stalled item lost from input register");

    // Starting a request always leaves a transfer in progress
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.start_tx |-> rsp.busy_res)
        else $error("start_tx without a transfer in progress");

    // An accepted frame clears the failure history and closes the exchange
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.frame_accepted |->
            rsp.ack && !rsp.busy_res && (rsp.fail_count == 8'd0) && !rsp.no_receiver)
        else $error("frame accepted with inconsistent status");

    // The receiver is only declared absent after at least one failure
    a_absent_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.no_receiver |-> (rsp.fail_count != 8'd0))
        else $error("no_receiver with zero failure count");

endmodule

`default_nettype wire
